>>> design/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the integer to decimal converter
// Holds the digit buffer size, character codes, sequencer states and the
// control and status bundles that pass between the sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam int MAX_DIGITS = 20;
  localparam int VAL_W      = 64;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int CNT_W      = $clog2(VAL_W + 1);
  localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);

  // Width select codes carried in func[2:1].
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;    // capture a new value and clear the digit register
    logic step;    // one shift-and-adjust iteration
    logic dshift;  // move the next digit to the top position
  } dp_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic [3:0] top_digit;
    logic       negative;
    logic       overflow;
  } dp_stat_t;

  // Number of significant bits for a width select code.
  function automatic logic [CNT_W-1:0] width_of(input logic [1:0] wsel);
    logic [CNT_W-1:0] w;
    w = CNT_W'(8) << wsel;
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: integer to decimal ASCII text
// Converts one 8, 16, 32 or 64 bit integer, signed or unsigned, into its
// decimal characters, most significant first, with a marker on the last one.
// ----------------------------------------------------------------------------
// An input beat carries the raw value and a type code in func: bit 0 set
// means signed, and bits 2:1 pick the width (0 = 8, 1 = 16, 2 = 32,
// 3 = 64 bits). Bits above the chosen width are ignored. The block answers
// with one output beat per character: a '-' for a negative signed value,
// then the digits of the magnitude with leading zeros removed, and
// last_char set on the final digit. Zero gives the single character '0'.
// The most negative value of each width converts correctly because the
// magnitude is formed as an unsigned two's complement negation.
//
// Operation: the conversion is a shift-and-add-3 binary to BCD loop that runs
// one magnitude bit per cycle through a single adjust-and-shift unit, over
// as many bits as the selected width (8 to 64). The digit register is then
// walked from the top: leading zeros are dropped one digit per cycle without
// a beat, and each character is emitted one per cycle while the output side
// accepts. in_ready is high only while the block has no item in progress;
// the final character may still sit in the output register while the next
// item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii
  import i2da_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [2:0]        func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      ascii_char,
  output logic                   last_char
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencer: bit counter, digit walk and the output register.
  i2da_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char),
    .ctrl       (ctrl),
    .stat       (stat)
  );

  // Datapath: operand preparation, magnitude shifter and BCD digits.
  i2da_dabble u_dabble (
    .clk   (clk),
    .value (value),
    .func  (func),
    .ctrl  (ctrl),
    .stat  (stat)
  );

endmodule

`default_nettype wire

>>> design/i2da_dabble.sv
// ----------------------------------------------------------------------------
// i2da_dabble: shift-and-add-3 binary to BCD datapath
// Holds the magnitude shift register and the BCD digit register. One shared
// adjust-and-shift unit runs once per magnitude bit; afterwards the digit
// register shifts up one digit at a time for emission.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dabble
  import i2da_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [2:0]        func,
  input  wire dp_ctrl_t          ctrl,
  output dp_stat_t               stat
);

  logic [VAL_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic             negative;
  logic             overflow;

  logic [VAL_W-1:0] mask;
  logic [VAL_W-1:0] x;
  logic             sign_bit;
  logic             neg_in;
  logic [VAL_W-1:0] mag_in;
  logic [VAL_W-1:0] aligned;
  logic [BCD_W-1:0] adj;

  // Operand preparation: mask to the width, take the magnitude, and align
  // its top bit to the top of the shift register.
  always_comb begin
    mask = '1;
    case (func[2:1])
      WSEL_8:  mask = VAL_W'({8{1'b1}});
      WSEL_16: mask = VAL_W'({16{1'b1}});
      WSEL_32: mask = VAL_W'({32{1'b1}});
      default: mask = '1;
    endcase
    x = value & mask;
    case (func[2:1])
      WSEL_8:  sign_bit = x[7];
      WSEL_16: sign_bit = x[15];
      WSEL_32: sign_bit = x[31];
      default: sign_bit = x[VAL_W-1];
    endcase
    neg_in = func[0] & sign_bit;
    mag_in = neg_in ? ((~x + VAL_W'(1)) & mask) : x;
    case (func[2:1])
      WSEL_8:  aligned = mag_in << (VAL_W - 8);
      WSEL_16: aligned = mag_in << (VAL_W - 16);
      WSEL_32: aligned = mag_in << (VAL_W - 32);
      default: aligned = mag_in;
    endcase
  end

  // Add 3 to every digit of 5 or more, so the following doubling carries
  // into the next digit correctly.
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag      <= aligned;
      bcd      <= '0;
      negative <= neg_in;
      overflow <= 1'b0;
    end else if (ctrl.step) begin
      mag      <= {mag[VAL_W-2:0], 1'b0};
      bcd      <= {adj[BCD_W-2:0], mag[VAL_W-1]};
      overflow <= overflow | adj[BCD_W-1];
    end else if (ctrl.dshift) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
    end
  end

  assign stat.top_digit = bcd[BCD_W-1 -: 4];
  assign stat.negative  = negative;
  assign stat.overflow  = overflow;

endmodule

`default_nettype wire

>>> design/i2da_ctrl.sv
// ----------------------------------------------------------------------------
// i2da_ctrl: conversion sequencer and output register
// Counts the shift iterations, then walks the digits from the top, drops
// leading zeros, emits the sign and digits, and holds each output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_ctrl
  import i2da_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      ascii_char,
  output logic                   last_char,
  output dp_ctrl_t               ctrl,
  input  wire dp_stat_t          stat
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  bits, bits_next;
  logic [DIG_W-1:0]  dig_left, dig_left_next;
  logic              sign_pending, sign_pending_next;
  logic              leading, leading_next;

  logic              out_free;
  logic              out_load;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bits         <= bits_next;
    dig_left     <= dig_left_next;
    sign_pending <= sign_pending_next;
    leading      <= leading_next;
  end

  always_comb begin
    state_next        = state;
    bits_next         = bits;
    dig_left_next     = dig_left;
    sign_pending_next = sign_pending;
    leading_next      = leading;
    ctrl              = '0;
    in_ready          = 1'b0;
    out_free          = !out_valid || out_ready;
    out_load          = 1'b0;
    out_char          = CH_ZERO;
    out_last          = 1'b0;
    last_pos          = (dig_left == DIG_W'(1));

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          bits_next  = width_of(func[2:1]);
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.step = 1'b1;
        bits_next = bits - CNT_W'(1);
        if (bits == CNT_W'(1)) begin
          dig_left_next     = DIG_W'(MAX_DIGITS);
          leading_next      = 1'b1;
          sign_pending_next = stat.negative;
          state_next        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sign_pending) begin
          if (out_free) begin
            out_load          = 1'b1;
            out_char          = CH_MINUS;
            sign_pending_next = 1'b0;
          end
        end else if (leading && stat.top_digit == 4'd0 && !stat.overflow && !last_pos) begin
          // Leading zero: drop it without a beat.
          ctrl.dshift   = 1'b1;
          dig_left_next = dig_left - DIG_W'(1);
        end else if (out_free) begin
          out_load      = 1'b1;
          out_char      = CH_ZERO + CHAR_W'(stat.top_digit);
          out_last      = last_pos;
          ctrl.dshift   = 1'b1;
          dig_left_next = dig_left - DIG_W'(1);
          leading_next  = 1'b0;
          if (last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ascii_char <= out_char;
      last_char  <= out_last;
    end
  end

endmodule

`default_nettype wire

>>> design/i2da_checker.sv
// ----------------------------------------------------------------------------
// i2da_checker: port-level checks for the integer to decimal converter
// Watches the top level's ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_checker
  import i2da_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] ascii_char,
  input wire logic              last_char
);

  // A stalled output beat holds its character and marker.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_char))
    else $error("output beat changed while stalled");

  // Once an item is taken, the block is busy converting it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after an accept");

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ascii_char == CH_MINUS ||
                   (ascii_char >= CH_ZERO && ascii_char <= CH_ZERO + CHAR_W'(9))))
    else $error("character out of range");

  // The sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ascii_char == CH_MINUS |-> !last_char)
    else $error("minus sign marked as last character");

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checks the integer to decimal ASCII converter
// Sends integers of every width and signedness through the input channel and
// compares each emitted character and its last marker with a predicted text.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [i2da_pkg::CHAR_W-1:0] ch;
  logic                        last;
} decimal_char_t;

// Builds the expected text of every accepted number and compares the
// characters that come out against it, oldest first.
class decimal_text_board;
  decimal_char_t expected_chars[$];
  int            errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  function void push_char(logic [i2da_pkg::CHAR_W-1:0] ch, logic last);
    decimal_char_t c;
    c.ch   = ch;
    c.last = last;
    expected_chars.push_back(c);
  endfunction

  // Works out the decimal text of one accepted number.
  function void note_number(logic [63:0] raw, logic [2:0] code);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] mag;
    logic [3:0]  digs[i2da_pkg::MAX_DIGITS];
    bit          negative;
    int          width;
    int          nd;
    width = 8 << code[2:1];
    mask  = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    x     = raw & mask;
    negative = code[0] && x[width-1];
    // Unsigned negation keeps the most negative value of each width exact.
    mag = negative ? (((~x) + 64'd1) & mask) : x;
    if (mag == 64'd0) begin
      push_char(i2da_pkg::CH_ZERO, 1'b1);
      return;
    end
    nd = 0;
    while (mag != 64'd0 && nd < i2da_pkg::MAX_DIGITS) begin
      digs[nd] = 4'(mag % 64'd10);
      mag      = mag / 64'd10;
      nd++;
    end
    if (negative) push_char(i2da_pkg::CH_MINUS, 1'b0);
    for (int i = nd - 1; i >= 0; i--) begin
      push_char(i2da_pkg::CH_ZERO + i2da_pkg::CHAR_W'(digs[i]), i == 0);
    end
  endfunction

  function void check_char(logic [i2da_pkg::CHAR_W-1:0] ch, logic last);
    decimal_char_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected character beat: ascii_char=%0d last_char=%0b", ch, last);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    if (ch !== want.ch) begin
      $error("ascii_char: expected %0d, got %0d", want.ch, ch);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_char: expected %0b, got %0b", want.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import i2da_pkg::*;

  localparam int RANDOM_ITEMS = 330;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [VAL_W-1:0]  value = '0;
  logic [2:0]        func = 3'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] ascii_char;
  logic              last_char;

  decimal_text_board board = new();
  int unsigned       cycle_count = 0;

  int_to_decimal_ascii uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both channels are watched at the clock edge. The testbench drives its
  // inputs with nonblocking assignments and the block's outputs settle after
  // its own register updates, so the values read here are the ones that
  // were present when the edge arrived.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_number(value, func);
      if (out_valid && out_ready) board.check_char(ascii_char, last_char);
    end
  end

  // The receiver steps through four stall styles in turn: always ready, coin
  // flips, ready only when the low three bits of the cycle counter are zero,
  // and mostly ready.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[8:7])
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_ready <= (cycle_count[2:0] == 3'd0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Presents one number and returns at the edge where it was taken. The
  // valid stays high afterwards, so a caller that sends again right away
  // gives a back-to-back beat.
  task automatic send_number(input logic [VAL_W-1:0] v, input logic [2:0] f);
    in_valid <= 1'b1;
    value    <= v;
    func     <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender back until every expected character has come out.
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] width_mask(input logic [2:0] f);
    int w;
    w = 8 << f[2:1];
    return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Random numbers with a spread of digit counts, powers of two and their
  // neighbors, small values and small negatives. Half of them carry junk
  // above the selected width, which the block must ignore.
  function automatic logic [63:0] random_number(input logic [2:0] f);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 20));
      3: v = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63);
      4: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
      default: v = ~64'($urandom_range(0, 20));
    endcase
    if ($urandom_range(0, 1) == 1) v = v | ({$urandom, $urandom} & ~width_mask(f));
    return v;
  endfunction

  initial begin
    logic [63:0] m;
    logic [2:0]  f;
    int          sent;
    int          burst;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: for every type code, a zero with the upper bits all
    // set, all ones (unsigned maximum or minus one), and the sign bit of the
    // width alone (most negative value when signed). Then the largest
    // signed 64 bit value.
    for (int c = 0; c < 8; c++) begin
      f = 3'(c);
      m = width_mask(f);
      send_number(~m, f);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, f);
      send_number((m >> 1) + 64'd1, f);
    end
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 3'd7);
    drain_text();

    // Random part, sent in bursts. Some bursts run straight into the next
    // with no gap at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        f = 3'($urandom_range(0, 7));
        send_number(random_number(f), f);
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_text();
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 15));
    end

    // The last number is noted at the edge where it was taken, so drain_text
    // first waits on the clock before looking at what is still expected.
    drain_text();
    // Any stray character after the last expected one would show up here.
    repeat (40) @(posedge clk);

    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Some 360 numbers are sent in all; a timeout of five milliseconds leaves
  // a wide margin.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
